// ----- hdl/pfe_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Playfair digraph encryptor: letter and key square types,
// configuration register indexes, reset values, and the pair coding functions.
// No dependencies.
package pfe_pkg;

    typedef logic [4:0]  letter_t;
    typedef logic [24:0] key_row_t;
    typedef logic [4:0][24:0] key_square_t;
    typedef logic [2:0]  cfg_index_t;
    typedef logic [2:0]  sq_idx_t;

    typedef struct packed {
        logic    found;
        sq_idx_t row;
        sq_idx_t col;
    } sq_loc_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    bad;
    } pair_code_t;

    localparam int SQ_DIM = 5;

    localparam cfg_index_t CFG_KEY_ROW_ZERO  = 3'd0;
    localparam cfg_index_t CFG_KEY_ROW_ONE   = 3'd1;
    localparam cfg_index_t CFG_KEY_ROW_TWO   = 3'd2;
    localparam cfg_index_t CFG_KEY_ROW_THREE = 3'd3;
    localparam cfg_index_t CFG_KEY_ROW_FOUR  = 3'd4;
    localparam cfg_index_t CFG_FILLER        = 3'd5;
    localparam cfg_index_t CFG_MERGED        = 3'd6;
    localparam cfg_index_t CFG_MERGED_INTO   = 3'd7;

    localparam key_row_t RST_KEY_ROW_ZERO  = 25'd11774221;
    localparam key_row_t RST_KEY_ROW_ONE   = 25'd12603073;
    localparam key_row_t RST_KEY_ROW_TWO   = 25'd17278404;
    localparam key_row_t RST_KEY_ROW_THREE = 25'd3824721;
    localparam key_row_t RST_KEY_ROW_FOUR  = 25'd27022514;
    localparam letter_t  RST_FILLER        = 5'd23;
    localparam letter_t  RST_MERGED        = 5'd6;
    localparam letter_t  RST_MERGED_INTO   = 5'd8;

    // Wrap to the next row or column of the square.
    function automatic sq_idx_t sq_next(input sq_idx_t idx);
        sq_idx_t res;
        res = (idx == sq_idx_t'(SQ_DIM - 1)) ? '0 : idx + 3'd1;
        return res;
    endfunction

    function automatic letter_t sq_cell(input key_square_t sq, input sq_idx_t r,
                                        input sq_idx_t c);
        key_row_t row;
        letter_t  res;
        row = sq[r];
        case (c)
            3'd0:    res = row[4:0];
            3'd1:    res = row[9:5];
            3'd2:    res = row[14:10];
            3'd3:    res = row[19:15];
            default: res = row[24:20];
        endcase
        return res;
    endfunction

    // First match in row-major order: scan backward so the earliest hit wins.
    function automatic sq_loc_t sq_locate(input key_square_t sq, input letter_t ltr);
        sq_loc_t loc;
        loc = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (sq[r][5*c +: 5] == ltr) begin
                    loc.found = 1'b1;
                    loc.row   = sq_idx_t'(r);
                    loc.col   = sq_idx_t'(c);
                end
            end
        end
        return loc;
    endfunction

    function automatic pair_code_t pair_encode(input key_square_t sq, input letter_t a,
                                               input letter_t b);
        sq_loc_t    la;
        sq_loc_t    lb;
        pair_code_t res;
        la = sq_locate(sq, a);
        lb = sq_locate(sq, b);
        res.bad = 1'b0;
        if (!la.found || !lb.found) begin
            res.first  = a;
            res.second = b;
            res.bad    = 1'b1;
        end else if (la.row == lb.row) begin
            res.first  = sq_cell(sq, la.row, sq_next(la.col));
            res.second = sq_cell(sq, lb.row, sq_next(lb.col));
        end else if (la.col == lb.col) begin
            res.first  = sq_cell(sq, sq_next(la.row), la.col);
            res.second = sq_cell(sq, sq_next(lb.row), lb.col);
        end else begin
            res.first  = sq_cell(sq, la.row, lb.col);
            res.second = sq_cell(sq, lb.row, la.col);
        end
        return res;
    endfunction

endpackage

// ----- hdl/playfair_digraph_encryptor.sv -----
`timescale 1ns / 1ps
// Top level of the Playfair digraph encryptor: pairing, key square lookup, output.
// Depends on pfe_pkg.
//
// Plaintext letters enter one per request; the merged letter is swapped for its
// partner, letters are paired (a doubled letter is split with the filler, an odd
// final letter is padded), and each pair is coded against the 5x5 key square
// held in five row registers. The output register hands out one cipher letter
// per cycle while out_ready is high, so every pair leaves as two letters, and
// one request can close two pairs (a doubled letter at message end). The first
// cipher letter of a pair is shown once the pair has moved from the job stage
// into the output register. A new request is taken while the previous pair is
// still draining.
// Configuration writes are taken at once and must only come while the block
// is idle.
module playfair_digraph_encryptor
    import pfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [24:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] plain_letter,
    input  logic       message_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] cipher_letter,
    output logic       bad_letter,
    output logic       run_last,
    output logic       message_end
);

    // Configuration registers
    key_square_t key_sq_reg;
    letter_t     filler_reg;
    letter_t     merged_reg;
    letter_t     merged_into_reg;

    // Pairing state
    letter_t held_letter_reg, held_letter_next;
    logic    held_valid_reg, held_valid_next;

    // Job stage: up to two pairs formed by one request
    logic [1:0] job_cnt_reg, job_cnt_next;
    letter_t    job_a_reg, job_a_next;
    letter_t    job_b_reg, job_b_next;
    letter_t    job_c_reg, job_c_next;
    logic       job_last_reg, job_last_next;

    // Output register: one coded pair, shown letter by letter
    logic       out_valid_reg, out_valid_next;
    logic       out_sel_reg, out_sel_next;
    letter_t    out_first_reg, out_first_next;
    letter_t    out_second_reg, out_second_next;
    logic       out_bad_reg, out_bad_next;
    logic       out_tail_reg, out_tail_next;
    logic       out_end_reg, out_end_next;

    letter_t    in_letter;
    logic       in_accept;
    logic       out_take;
    logic       pair_move;
    pair_code_t pair_code;
    logic [1:0] new_cnt;
    letter_t    new_a;
    letter_t    new_b;

    // ---------------------------------------------------------------------
    // Configuration write port
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_sq_reg[0]   <= RST_KEY_ROW_ZERO;
            key_sq_reg[1]   <= RST_KEY_ROW_ONE;
            key_sq_reg[2]   <= RST_KEY_ROW_TWO;
            key_sq_reg[3]   <= RST_KEY_ROW_THREE;
            key_sq_reg[4]   <= RST_KEY_ROW_FOUR;
            filler_reg      <= RST_FILLER;
            merged_reg      <= RST_MERGED;
            merged_into_reg <= RST_MERGED_INTO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_ROW_ZERO:  key_sq_reg[0]   <= cfg_data;
                CFG_KEY_ROW_ONE:   key_sq_reg[1]   <= cfg_data;
                CFG_KEY_ROW_TWO:   key_sq_reg[2]   <= cfg_data;
                CFG_KEY_ROW_THREE: key_sq_reg[3]   <= cfg_data;
                CFG_KEY_ROW_FOUR:  key_sq_reg[4]   <= cfg_data;
                CFG_FILLER:        filler_reg      <= cfg_data[4:0];
                CFG_MERGED:        merged_reg      <= cfg_data[4:0];
                CFG_MERGED_INTO:   merged_into_reg <= cfg_data[4:0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign out_take  = out_valid_reg && out_ready;
    // Move the head pair into the output register once it is empty or its
    // second letter leaves this cycle.
    assign pair_move = (job_cnt_reg != 2'd0) && (!out_valid_reg || (out_sel_reg && out_ready));
    // Take a new request when the job stage is empty or drains its last pair now.
    assign in_ready  = (job_cnt_reg == 2'd0) || ((job_cnt_reg == 2'd1) && pair_move);
    assign in_accept = in_valid && in_ready;

    // ---------------------------------------------------------------------
    // Pair formation on the incoming letter
    // ---------------------------------------------------------------------
    assign in_letter = (plain_letter == merged_reg) ? merged_into_reg : plain_letter;

    always_comb
    begin
        new_cnt          = 2'd0;
        new_a            = held_letter_reg;
        new_b            = filler_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        if (held_valid_reg)
        begin
            if (held_letter_reg == in_letter)
            begin
                // Doubled letter: close with the filler, keep the letter open;
                // at message end it is padded as a second pair.
                new_cnt          = message_last ? 2'd2 : 2'd1;
                held_letter_next = in_letter;
            end
            else
            begin
                new_cnt         = 2'd1;
                new_b           = in_letter;
                held_valid_next = 1'b0;
            end
        end
        else
        begin
            // Hold the letter; pad it at once if the message ends here.
            new_a            = in_letter;
            new_cnt          = message_last ? 2'd1 : 2'd0;
            held_letter_next = in_letter;
            held_valid_next  = 1'b1;
        end
        if (message_last)
        begin
            held_letter_next = '0;
            held_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // Job stage
    // ---------------------------------------------------------------------
    always_comb
    begin
        job_cnt_next  = job_cnt_reg;
        job_a_next    = job_a_reg;
        job_b_next    = job_b_reg;
        job_c_next    = job_c_reg;
        job_last_next = job_last_reg;
        if (pair_move)
        begin
            if (job_cnt_reg == 2'd2)
            begin
                // Advance to the padded second pair.
                job_cnt_next = 2'd1;
                job_a_next   = job_c_reg;
                job_b_next   = filler_reg;
            end
            else
            begin
                job_cnt_next = 2'd0;
            end
        end
        if (in_accept)
        begin
            job_cnt_next  = new_cnt;
            job_a_next    = new_a;
            job_b_next    = new_b;
            job_c_next    = in_letter;
            job_last_next = message_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_cnt_reg <= 2'd0;
        end
        else
        begin
            job_cnt_reg <= job_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_a_reg    <= job_a_next;
        job_b_reg    <= job_b_next;
        job_c_reg    <= job_c_next;
        job_last_reg <= job_last_next;
    end

    // ---------------------------------------------------------------------
    // Key square lookup and output register
    // ---------------------------------------------------------------------
    assign pair_code = pair_encode(key_sq_reg, job_a_reg, job_b_reg);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sel_next    = out_sel_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_bad_next    = out_bad_reg;
        out_tail_next   = out_tail_reg;
        out_end_next    = out_end_reg;
        if (pair_move)
        begin
            out_valid_next  = 1'b1;
            out_sel_next    = 1'b0;
            out_first_next  = pair_code.first;
            out_second_next = pair_code.second;
            out_bad_next    = pair_code.bad;
            out_tail_next   = (job_cnt_reg == 2'd1);
            out_end_next    = (job_cnt_reg == 2'd1) && job_last_reg;
        end
        else if (out_take)
        begin
            if (!out_sel_reg)
            begin
                out_sel_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
                out_sel_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_sel_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_sel_reg   <= out_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_bad_reg    <= out_bad_next;
        out_tail_reg   <= out_tail_next;
        out_end_reg    <= out_end_next;
    end

    assign out_valid     = out_valid_reg;
    assign cipher_letter = out_sel_reg ? out_second_reg : out_first_reg;
    assign bad_letter    = out_bad_reg;
    assign run_last      = out_sel_reg && out_tail_reg;
    assign message_end   = out_sel_reg && out_end_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_job_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_cnt_reg != 2'd3)
        else $error("job stage holds more than two pairs");

    a_sel_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_sel_reg |-> out_valid_reg)
        else $error("second letter selected with no pair in the output register");

    a_last_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && message_last) |=> !held_valid_reg)
        else $error("letter still held after the end of a message");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_end) |-> run_last)
        else $error("message end flagged on a letter that is not the last of its request");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_sel_reg) |-> !pair_move)
        else $error("pair moved over an undelivered first letter");

endmodule
